>>> rtl/rn_pkg.sv
package rn_pkg;

   localparam int WIDTH      = 32;
   localparam int CNT_W      = $clog2(WIDTH);
   localparam int IN_DATA_W  = ((2 * WIDTH + 7) / 8) * 8;
   localparam int OUT_DATA_W = ((2 * WIDTH - 1 + 7) / 8) * 8;

   localparam logic [WIDTH-1:0] MAG_MAX = {1'b0, {(WIDTH-1){1'b1}}};

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_GCD,
      ST_DIV,
      ST_WRITE
   } rn_state_type;

   typedef struct packed {
      logic load;
      logic gcd_step;
      logic div_init;
      logic div_step;
      logic out_load;
   } rn_cmd_type;

   typedef struct packed {
      logic nzero;
      logic gcd_done;
   } rn_sts_type;

endpackage

>>> rtl/rn_dp.sv
module rn_dp
   import rn_pkg::*;
(
   input  logic                   clock,
   input  logic [WIDTH-1:0]       num_in,
   input  logic [WIDTH-1:0]       den_in,
   input  rn_cmd_type             cmd,
   output rn_sts_type             sts,
   output logic [WIDTH-1:0]       num_out,
   output logic [WIDTH-2:0]       den_out
);

   logic [WIDTH-1:0] nmag_ff, nmag_in;
   logic [WIDTH-1:0] dmag_ff, dmag_in;
   logic             neg_ff, neg_in;
   logic [WIDTH-1:0] a_ff, a_in;
   logic [WIDTH-1:0] b_ff, b_in;
   logic [CNT_W-1:0] k_ff, k_in;
   logic [WIDTH-1:0] g_ff, g_in;
   logic [WIDTH-1:0] qn_ff, qn_in;
   logic [WIDTH-1:0] qd_ff, qd_in;
   logic [WIDTH-1:0] rn_ff, rn_in;
   logic [WIDTH-1:0] rd_ff, rd_in;
   logic [WIDTH-1:0] num_out_ff, num_out_in;
   logic [WIDTH-2:0] den_out_ff, den_out_in;

   logic [WIDTH:0]   tn, td;
   logic [WIDTH:0]   tn_sub, td_sub;
   logic [WIDTH-1:0] qn_sat, qd_sat;

   assign sts.nzero    = (nmag_ff == '0);
   assign sts.gcd_done = (a_ff == b_ff) || (b_ff == '0);

   always_comb begin
      nmag_in = nmag_ff;
      dmag_in = dmag_ff;
      neg_in  = neg_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      k_in    = k_ff;
      if (cmd.load) begin
         nmag_in = num_in[WIDTH-1] ? (~num_in + 1'b1) : num_in;
         dmag_in = den_in[WIDTH-1] ? (~den_in + 1'b1) : den_in;
         neg_in  = num_in[WIDTH-1] ^ den_in[WIDTH-1];
         a_in    = nmag_in;
         b_in    = dmag_in;
         k_in    = '0;
      end else if (cmd.gcd_step) begin
         priority if (!a_ff[0] && !b_ff[0]) begin
            a_in = a_ff >> 1;
            b_in = b_ff >> 1;
            k_in = k_ff + 1'b1;
         end else if (!a_ff[0]) begin
            a_in = a_ff >> 1;
         end else if (!b_ff[0]) begin
            b_in = b_ff >> 1;
         end else if (a_ff > b_ff) begin
            a_in = (a_ff - b_ff) >> 1;
         end else begin
            b_in = (b_ff - a_ff) >> 1;
         end
      end
   end

   assign tn     = {rn_ff, qn_ff[WIDTH-1]};
   assign td     = {rd_ff, qd_ff[WIDTH-1]};
   assign tn_sub = tn - {1'b0, g_ff};
   assign td_sub = td - {1'b0, g_ff};

   always_comb begin
      g_in  = g_ff;
      qn_in = qn_ff;
      qd_in = qd_ff;
      rn_in = rn_ff;
      rd_in = rd_ff;
      if (cmd.div_init) begin
         g_in  = a_ff << k_ff;
         qn_in = nmag_ff;
         qd_in = dmag_ff;
         rn_in = '0;
         rd_in = '0;
      end else if (cmd.div_step) begin
         if (!tn_sub[WIDTH]) begin
            rn_in = tn_sub[WIDTH-1:0];
            qn_in = {qn_ff[WIDTH-2:0], 1'b1};
         end else begin
            rn_in = tn[WIDTH-1:0];
            qn_in = {qn_ff[WIDTH-2:0], 1'b0};
         end
         if (!td_sub[WIDTH]) begin
            rd_in = td_sub[WIDTH-1:0];
            qd_in = {qd_ff[WIDTH-2:0], 1'b1};
         end else begin
            rd_in = td[WIDTH-1:0];
            qd_in = {qd_ff[WIDTH-2:0], 1'b0};
         end
      end
   end

   assign qn_sat = qn_ff[WIDTH-1] ? MAG_MAX : qn_ff;
   assign qd_sat = qd_ff[WIDTH-1] ? MAG_MAX : qd_ff;

   always_comb begin
      num_out_in = num_out_ff;
      den_out_in = den_out_ff;
      if (cmd.out_load) begin
         if (sts.nzero) begin
            num_out_in = '0;
            den_out_in = {{(WIDTH-2){1'b0}}, 1'b1};
         end else begin
            num_out_in = neg_ff ? (~qn_sat + 1'b1) : qn_sat;
            den_out_in = qd_sat[WIDTH-2:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      nmag_ff    <= nmag_in;
      dmag_ff    <= dmag_in;
      neg_ff     <= neg_in;
      a_ff       <= a_in;
      b_ff       <= b_in;
      k_ff       <= k_in;
      g_ff       <= g_in;
      qn_ff      <= qn_in;
      qd_ff      <= qd_in;
      rn_ff      <= rn_in;
      rd_ff      <= rd_in;
      num_out_ff <= num_out_in;
      den_out_ff <= den_out_in;
   end

   assign num_out = num_out_ff;
   assign den_out = den_out_ff;

endmodule

>>> rtl/rn_ctrl.sv
module rn_ctrl
   import rn_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  rn_sts_type sts,
   output rn_cmd_type cmd
);

   rn_state_type     state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             valid_ff, valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_GCD;
            end
         end
         ST_GCD: begin
            priority if (sts.nzero) begin
               state_in = ST_WRITE;
            end else if (sts.gcd_done) begin
               cmd.div_init = 1'b1;
               cnt_in       = '0;
               state_in     = ST_DIV;
            end else begin
               cmd.gcd_step = 1'b1;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == CNT_W'(WIDTH - 1)) begin
               cnt_in   = '0;
               state_in = ST_WRITE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_WRITE: begin
            if (!valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.out_load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   assign rsp_tvalid = valid_ff;

endmodule

>>> rtl/rational_normalize.sv
// channel | ports | tdata fields, low bit up
// req     | req_tvalid, req_tready, req_tdata  | num_in[31:0], den_in[63:32]
// rsp     | rsp_tvalid, rsp_tready, rsp_tdata  | num_out[31:0], den_out[62:32], zero[63]
// One item at a time: accept, a binary gcd loop, forming the divisor, restoring
// division of both magnitudes at once, then loading the result register.
// A zero numerator skips the gcd and division; the gcd loop length varies.
// Reset is synchronous; the result register holds while rsp_tready is low and
// the next item is taken while a finished result waits.
module rational_normalize
   import rn_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [IN_DATA_W-1:0]  req_tdata,   // num_in, den_in
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [OUT_DATA_W-1:0] rsp_tdata    // num_out, den_out, zero fill
);

   rn_cmd_type       cmd;
   rn_sts_type       sts;
   logic [WIDTH-1:0] num_out;
   logic [WIDTH-2:0] den_out;

   rn_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   rn_dp u_dp (
      .clock   (clock),
      .num_in  (req_tdata[WIDTH-1:0]),
      .den_in  (req_tdata[2*WIDTH-1:WIDTH]),
      .cmd     (cmd),
      .sts     (sts),
      .num_out (num_out),
      .den_out (den_out)
   );

   assign rsp_tdata = OUT_DATA_W'({den_out, num_out});

endmodule

>>> rtl/rn_checker.sv
module rn_checker
   import rn_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [OUT_DATA_W-1:0] rsp_tdata
);

   logic [WIDTH-1:0] num_w;
   logic [WIDTH-2:0] den_w;

   assign num_w = rsp_tdata[WIDTH-1:0];
   assign den_w = rsp_tdata[2*WIDTH-2:WIDTH];

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("item accepted while busy");

   a_zero_den: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && den_w == '0 |-> num_w == WIDTH'(1) || num_w == '1)
      else $error("zero denominator with unreduced numerator");

   a_zero_num: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && num_w == '0 |-> den_w == (WIDTH-1)'(1))
      else $error("zero numerator without unit denominator");

endmodule

bind rational_normalize rn_checker u_rn_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
